@@ src/svpwm_pkg.sv @@
// Package: shared constants and types for the space-vector PWM block.
package svpwm_pkg;

	localparam int unsigned CompareWidth = 16;
	localparam int unsigned CellCount = 4;
	localparam int unsigned DivBits = 17;
	localparam int unsigned DivPerCell = (DivBits + CellCount - 1) / CellCount;
	localparam logic [16:0] Sqrt3Q16 = 17'd113512;
	localparam int unsigned NumWidth = 51;
	localparam int unsigned SqrtSteps = 25;
	localparam int unsigned SqrtStages = 5;
	localparam int unsigned SqrtPerStage = SqrtSteps / SqrtStages;

	typedef enum logic [1:0] {
		CFG_SUPPLY = 2'd0,
		CFG_PERIOD = 2'd1,
		CFG_SWAP   = 2'd2
	} cfg_index_t;

	typedef logic [2:0] sector_t;

	// Square-root state and the fields that travel alongside it.
	typedef struct packed {
		logic [49:0] rad;
		logic [49:0] root;
		logic lim;
		logic [15:0] vdc;
		logic signed [36:0] ta;
		logic signed [36:0] tb;
		sector_t sector;
	} root_word_t;

	// Per-phase division state: partial remainder and quotient being formed.
	typedef struct packed {
		logic [NumWidth:0] rem;
		logic [DivBits-1:0] quo;
	} div_lane_t;

	// Everything a division cell hands to its right neighbour.
	typedef struct packed {
		logic valid;
		div_lane_t [3:0] lane;
		logic [NumWidth-1:0] den;
		logic [CompareWidth-1:0] period;
		logic zero_den;
		sector_t sector;
		logic limited;
		logic swap;
	} div_word_t;

endpackage

@@ src/svpwm_if.sv @@
// Interfaces: valid/ready channels for commands and compare results.
interface svpwm_cmd_if (input logic clk);
	logic valid;
	logic ready;
	logic signed [15:0] u_alpha;
	logic signed [15:0] u_beta;
	modport source (output valid, u_alpha, u_beta, input ready);
	modport sink (input valid, u_alpha, u_beta, output ready);
endinterface

interface svpwm_res_if (input logic clk);
	logic valid;
	logic ready;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [2:0] sector_index;
	logic magnitude_limited;
	modport source (output valid, compare_a, compare_b, compare_c, sector_index,
		magnitude_limited, input ready);
	modport sink (input valid, compare_a, compare_b, compare_c, sector_index,
		magnitude_limited, output ready);
endinterface

@@ src/svpwm_front.sv @@
// Front end: magnitude, limit test, sector, square root and scaled phase numerators.
module svpwm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic in_valid,
	input  logic signed [15:0] u_alpha,
	input  logic signed [15:0] u_beta,
	input  logic [15:0] supply_voltage,
	input  logic [15:0] timer_period,
	input  logic swap_phase_bc,
	output svpwm_pkg::div_word_t word_out
);
	// Stage 1: squares and sector.
	logic v_s1, v_s2, v_s8, v_s9, v_s10;
	logic [32:0] mag3_s1;
	logic [31:0] vdc2_s1;
	logic signed [16:0] x_s1, y_s1;
	logic [1:0] s_s1;
	logic [2:0] sector_s1;
	logic [15:0] vdc_s1;

	logic signed [16:0] xa, ya;
	logic signed [33:0] xx, yy;
	logic [34:0] xx3;
	logic base;
	logic [1:0] s_c;

	always_comb begin
		base = (u_beta < 0) || (u_beta == 0 && u_alpha < 0);
		xa = base ? -17'(u_alpha) : 17'(u_alpha);
		ya = base ? -17'(u_beta) : 17'(u_beta);
		xx = xa * xa;
		yy = ya * ya;
		xx3 = 35'(xx) * 35'd3;
		if (ya == 0) s_c = 2'd0;
		else if (xa > 0 && 35'(yy) < xx3) s_c = 2'd0;
		else if (xa >= 0 || xx3 < 35'(yy)) s_c = 2'd1;
		else s_c = 2'd2;
	end

	// 3*(a^2+b^2) needs 33 bits: at most 3*2^31.
	logic [33:0] mag3_c;
	assign mag3_c = 34'(3) * (34'(xx[31:0]) + 34'(yy[31:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag3_s1 <= mag3_c[32:0];
			vdc2_s1 <= 32'(supply_voltage) * 32'(supply_voltage);
			x_s1 <= xa;
			y_s1 <= ya;
			s_s1 <= s_c;
			sector_s1 <= (base ? 3'd3 : 3'd0) + 3'(s_c);
			vdc_s1 <= supply_voltage;
		end
	end

	// Stage 2: limit flag, P and Q, active times.
	logic lim_s2;
	logic [32:0] mag3_s2;
	logic [15:0] vdc_s2;
	logic signed [36:0] ta_s2, tb_s2;
	logic [2:0] sector_s2;
	logic signed [36:0] p_c, q_c, ta_c, tb_c;

	always_comb begin
		p_c = 37'(x_s1) * 37'sd196608;
		q_c = 37'(y_s1) * $signed({20'd0, svpwm_pkg::Sqrt3Q16});
		unique case (s_s1)
			2'd0: begin
				ta_c = p_c - q_c;
				tb_c = q_c + q_c;
			end
			2'd1: begin
				ta_c = p_c + q_c;
				tb_c = q_c - p_c;
			end
			default: begin
				ta_c = q_c + q_c;
				tb_c = -p_c - q_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lim_s2 <= mag3_s1 > 33'(vdc2_s1);
			mag3_s2 <= mag3_s1;
			vdc_s2 <= vdc_s1;
			ta_s2 <= ta_c;
			tb_s2 <= tb_c;
			sector_s2 <= sector_s1;
		end
	end

	// Stages 3 to 7: integer square root of mag3*2^16 (25-bit result), five radix-4
	// steps per stage. Entry k of rt_s3 and rv_s3 is the word held after stage 3+k.
	svpwm_pkg::root_word_t rt_head;
	svpwm_pkg::root_word_t rt_in [svpwm_pkg::SqrtStages];
	svpwm_pkg::root_word_t rt_c [svpwm_pkg::SqrtStages];
	svpwm_pkg::root_word_t rt_s3 [svpwm_pkg::SqrtStages];
	logic rv_in [svpwm_pkg::SqrtStages];
	logic rv_s3 [svpwm_pkg::SqrtStages];

	always_comb begin
		rt_head.rad = {1'b0, mag3_s2, 16'd0};
		rt_head.root = '0;
		rt_head.lim = lim_s2;
		rt_head.vdc = vdc_s2;
		rt_head.ta = ta_s2;
		rt_head.tb = tb_s2;
		rt_head.sector = sector_s2;
	end

	assign rt_in[0] = rt_head;
	assign rv_in[0] = v_s2;
	for (genvar g = 1; g < svpwm_pkg::SqrtStages; g++) begin : g_root_link
		assign rt_in[g] = rt_s3[g-1];
		assign rv_in[g] = rv_s3[g-1];
	end

	always_comb begin
		svpwm_pkg::root_word_t w;
		logic [49:0] b;
		logic [50:0] t;
		for (int k = 0; k < svpwm_pkg::SqrtStages; k++) begin
			w = rt_in[k];
			for (int j = 0; j < svpwm_pkg::SqrtPerStage; j++) begin
				b = 50'd1 << (48 - 2 * (k * svpwm_pkg::SqrtPerStage + j));
				t = 51'(w.root) + 51'(b);
				if (51'(w.rad) >= t) begin
					w.rad = w.rad - t[49:0];
					w.root = (w.root >> 1) + b;
				end else begin
					w.root = w.root >> 1;
				end
			end
			rt_c[k] = w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < svpwm_pkg::SqrtStages; k++) rv_s3[k] <= 1'b0;
		end else if (advance) begin
			for (int k = 0; k < svpwm_pkg::SqrtStages; k++) rv_s3[k] <= rv_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < svpwm_pkg::SqrtStages; k++) rt_s3[k] <= rt_c[k];
		end
	end

	// Stage 8: denominator base, the root when limited, else the supply.
	svpwm_pkg::root_word_t rt_last;
	assign rt_last = rt_s3[svpwm_pkg::SqrtStages-1];

	logic [24:0] d_s8;
	logic lim_s8;
	logic signed [36:0] ta_s8, tb_s8;
	logic [2:0] sector_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (advance) begin
			v_s8 <= rv_s3[svpwm_pkg::SqrtStages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_s8 <= rt_last.lim ? rt_last.root[24:0] : {1'b0, rt_last.vdc, 8'd0};
			lim_s8 <= rt_last.lim;
			ta_s8 <= rt_last.ta;
			tb_s8 <= rt_last.tb;
			sector_s8 <= rt_last.sector;
		end
	end

	// Stage 9: numerators, clamped to [0, 2N].
	logic signed [38:0] n_c;
	logic signed [38:0] num_c [4];
	logic [34:0] clamp_c [4];
	assign n_c = $signed({5'd0, d_s8, 9'd0});

	always_comb begin
		num_c[0] = n_c + 39'(ta_s8) + 39'(tb_s8);
		num_c[1] = n_c + 39'(ta_s8) - 39'(tb_s8);
		num_c[2] = n_c - 39'(ta_s8) + 39'(tb_s8);
		num_c[3] = n_c - 39'(ta_s8) - 39'(tb_s8);
		for (int k = 0; k < 4; k++) begin
			if (num_c[k] < 0) clamp_c[k] = '0;
			else if (num_c[k] > (n_c <<< 1)) clamp_c[k] = 35'(n_c <<< 1);
			else clamp_c[k] = num_c[k][34:0];
		end
	end

	logic [34:0] clamp_s9 [4];
	logic [34:0] den_s9;
	logic [15:0] per_s9;
	logic zero_s9, lim_s9, swap_s9;
	logic [2:0] sector_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (advance) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < 4; k++) clamp_s9[k] <= clamp_c[k];
			den_s9 <= 35'(n_c <<< 1);
			per_s9 <= timer_period;
			zero_s9 <= (d_s8 == '0);
			lim_s9 <= lim_s8;
			swap_s9 <= swap_phase_bc;
			sector_s9 <= sector_s8;
		end
	end

	// Stage 10: products num*period (< 2^51) are built from two 35x8 partials.
	svpwm_pkg::div_word_t word_c;
	svpwm_pkg::div_word_t word_s10;

	always_comb begin
		logic [50:0] prod;
		word_c = '0;
		for (int k = 0; k < 4; k++) begin
			prod = (51'(clamp_s9[k]) * 51'(per_s9[7:0]))
				+ ((51'(clamp_s9[k]) * 51'(per_s9[15:8])) << 8);
			word_c.lane[k].rem = {1'b0, prod};
			word_c.lane[k].quo = '0;
		end
		word_c.den = {16'd0, den_s9};
		word_c.period = per_s9;
		word_c.zero_den = zero_s9;
		word_c.sector = sector_s9;
		word_c.limited = lim_s9;
		word_c.swap = swap_s9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (advance) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s10 <= word_c;
		end
	end

	always_comb begin
		word_out = word_s10;
		word_out.valid = v_s10;
	end
endmodule

@@ src/svpwm_div_cell.sv @@
// Division cell: a few restoring-division steps for four phase lanes.
module svpwm_div_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [4:0] first_bit,
	input  svpwm_pkg::div_word_t word_in,
	output svpwm_pkg::div_word_t word_out
);
	svpwm_pkg::div_word_t nxt;
	svpwm_pkg::div_word_t data_q;
	logic valid_q;

	always_comb begin
		logic [96:0] sh;
		sh = '0;
		nxt = word_in;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < svpwm_pkg::DivPerCell; j++) begin
				if (int'(first_bit) - j >= 0) begin
					sh = 97'(word_in.den) << (int'(first_bit) - j);
					if (97'(nxt.lane[k].rem) >= sh) begin
						nxt.lane[k].rem = nxt.lane[k].rem - sh[svpwm_pkg::NumWidth:0];
						nxt.lane[k].quo[int'(first_bit) - j] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		word_out = data_q;
		word_out.valid = valid_q;
	end
endmodule

@@ src/space_vector_pwm_duty_top.sv @@
// Top level: space-vector PWM compare generator with its configuration registers.
//
//  channel | direction | words
//  cmd     | in        | u_alpha, u_beta (signed Q7.8 volts)
//  res     | out       | compare_a/b/c, sector_index, magnitude_limited
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// A word passes ten front-end stages (two for squares and active times, five for
// the square root, three for the denominator, numerators and period products), then
// four division cells and the output slot, and a new word may enter every cycle
// while the pipeline advances. The whole pipeline advances together and halts
// while the output word waits unread.
// Reset clears the valid flags and restores the register defaults.
module space_vector_pwm_duty_top (
	input  logic clk,
	input  logic arst_n,
	svpwm_cmd_if.sink cmd,
	svpwm_res_if.source res,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] supply_q, period_q;
	logic swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 16'd3072;
			period_q <= 16'd4095;
			swap_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svpwm_pkg::CFG_SUPPLY: supply_q <= cfg_data;
				svpwm_pkg::CFG_PERIOD: period_q <= cfg_data;
				svpwm_pkg::CFG_SWAP: swap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output slot is empty or being taken.
	logic advance;
	logic out_valid_q;
	assign advance = !out_valid_q || res.ready;
	assign cmd.ready = advance;

	svpwm_pkg::div_word_t chain [svpwm_pkg::CellCount+1];

	svpwm_front u_front (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.in_valid(cmd.valid), .u_alpha(cmd.u_alpha), .u_beta(cmd.u_beta),
		.supply_voltage(supply_q), .timer_period(period_q),
		.swap_phase_bc(swap_q), .word_out(chain[0])
	);

	for (genvar g = 0; g < svpwm_pkg::CellCount; g++) begin : g_cell
		svpwm_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.first_bit(5'(svpwm_pkg::DivBits - 1 - g * svpwm_pkg::DivPerCell)),
			.word_in(chain[g]), .word_out(chain[g+1])
		);
	end

	// Output slot: pick the phase counts by sector (half the period for a zero denominator), saturate and swap.
	svpwm_pkg::div_word_t last;
	assign last = chain[svpwm_pkg::CellCount];
	logic [15:0] cnt [4];
	logic [15:0] ca, cb, cc;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cnt[k] = (last.lane[k].quo > 17'hFFFF) ? 16'hFFFF : last.lane[k].quo[15:0];
		end
		if (last.zero_den) begin
			ca = last.period >> 1;
			cb = ca;
			cc = ca;
		end else begin
			unique case (last.sector)
				3'd0: begin ca = cnt[0]; cb = cnt[2]; cc = cnt[3]; end
				3'd1: begin ca = cnt[1]; cb = cnt[0]; cc = cnt[3]; end
				3'd2: begin ca = cnt[3]; cb = cnt[0]; cc = cnt[2]; end
				3'd3: begin ca = cnt[3]; cb = cnt[1]; cc = cnt[0]; end
				3'd4: begin ca = cnt[2]; cb = cnt[3]; cc = cnt[0]; end
				default: begin ca = cnt[0]; cb = cnt[3]; cc = cnt[1]; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res.compare_a <= ca;
			res.compare_b <= last.swap ? cc : cb;
			res.compare_c <= last.swap ? cb : cc;
			res.sector_index <= last.sector;
			res.magnitude_limited <= last.limited;
		end
	end

	assign res.valid = out_valid_q;
endmodule

@@ dv/space_vector_pwm_duty_top_test.sv @@
// Testbench for the space-vector PWM compare generator: random and directed commands, scoreboard.
`timescale 1ns / 1ps

module space_vector_pwm_duty_top_test;

	// One compare result word as the block presents it.
	typedef struct packed {
		logic [15:0] compare_a;
		logic [15:0] compare_b;
		logic [15:0] compare_c;
		logic [2:0] sector_index;
		logic magnitude_limited;
	} duty_word_t;

	// Scoreboard: holds a copy of the registers, works out the compare word for each
	// accepted command word and checks every result word against the oldest one.
	class duty_scoreboard;
		logic [15:0] supply;
		logic [15:0] period;
		logic swap_bc;
		duty_word_t awaited[$];
		int errors;

		function void restore_defaults();
			supply = 16'd3072;
			period = 16'd4095;
			swap_bc = 1'b0;
			errors = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function logic [15:0] duty_count(longint num, longint den);
			longint unsigned c;
			if (num < 0)
				num = 0;
			if (num > 2 * den)
				num = 2 * den;
			c = (longint'(num) * longint'(period)) / (den * 2);
			return (c > 65535) ? 16'hFFFF : c[15:0];
		endfunction

		function duty_word_t duty_of(logic signed [15:0] ua, logic signed [15:0] ub);
			duty_word_t w;
			longint x, y, p, q, ta, tb, n, mag3;
			longint unsigned d;
			logic [15:0] top, m1, m2, bot, t;
			int base, s, sec;
			x = ua;
			y = ub;
			mag3 = 3 * (x * x + y * y);
			w.magnitude_limited = mag3 > longint'(supply) * longint'(supply);
			base = 0;
			if (y < 0 || (y == 0 && x < 0)) begin
				x = -x;
				y = -y;
				base = 3;
			end
			if (y == 0)
				s = 0;
			else if (x > 0 && y * y < 3 * x * x)
				s = 0;
			else if (x >= 0 || 3 * x * x < y * y)
				s = 1;
			else
				s = 2;
			sec = base + s;
			p = 3 * x * 65536;
			q = y * 113512;
			if (s == 0) begin
				ta = p - q;
				tb = 2 * q;
			end else if (s == 1) begin
				ta = p + q;
				tb = q - p;
			end else begin
				ta = 2 * q;
				tb = -p - q;
			end
			d = w.magnitude_limited ? int_sqrt(mag3 << 16) : (longint'(supply) << 8);
			n = d << 9;
			if (n == 0) begin
				top = duty_count(1, 1);
				w.compare_a = top;
				w.compare_b = top;
				w.compare_c = top;
			end else begin
				top = duty_count(n + ta + tb, n);
				m1 = duty_count(n + ta - tb, n);
				m2 = duty_count(n - ta + tb, n);
				bot = duty_count(n - ta - tb, n);
				case (sec)
					0: begin w.compare_a = top; w.compare_b = m2; w.compare_c = bot; end
					1: begin w.compare_a = m1; w.compare_b = top; w.compare_c = bot; end
					2: begin w.compare_a = bot; w.compare_b = top; w.compare_c = m2; end
					3: begin w.compare_a = bot; w.compare_b = m1; w.compare_c = top; end
					4: begin w.compare_a = m2; w.compare_b = bot; w.compare_c = top; end
					default: begin w.compare_a = top; w.compare_b = bot; w.compare_c = m1; end
				endcase
			end
			if (swap_bc) begin
				t = w.compare_b;
				w.compare_b = w.compare_c;
				w.compare_c = t;
			end
			w.sector_index = sec[2:0];
			return w;
		endfunction

		function void note_command(logic signed [15:0] ua, logic signed [15:0] ub);
			awaited.push_back(duty_of(ua, ub));
		endfunction

		function void check_result(duty_word_t got);
			duty_word_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result word, actual %h", $time, got);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.compare_a !== e.compare_a) begin
				$display("%0t: compare_a expected %0d actual %0d", $time, e.compare_a, got.compare_a);
				errors++;
			end
			if (got.compare_b !== e.compare_b) begin
				$display("%0t: compare_b expected %0d actual %0d", $time, e.compare_b, got.compare_b);
				errors++;
			end
			if (got.compare_c !== e.compare_c) begin
				$display("%0t: compare_c expected %0d actual %0d", $time, e.compare_c, got.compare_c);
				errors++;
			end
			if (got.sector_index !== e.sector_index) begin
				$display("%0t: sector_index expected %0d actual %0d", $time, e.sector_index,
					got.sector_index);
				errors++;
			end
			if (got.magnitude_limited !== e.magnitude_limited) begin
				$display("%0t: magnitude_limited expected %0b actual %0b", $time,
					e.magnitude_limited, got.magnitude_limited);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	svpwm_cmd_if cmd (.clk(clk));
	svpwm_res_if res (.clk(clk));

	space_vector_pwm_duty_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.res(res.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	duty_scoreboard sb;

	// Idling odds in percent for each side; the stimulus moves them between stretches.
	int send_idle_pct;
	int recv_idle_pct;
	// Every accepted word on either channel bumps this; the watchdog looks for progress.
	int unsigned words_moved;
	int unsigned items_sent;

	localparam int unsigned RandomItems = 1540;
	localparam int unsigned StallLimit = 5000;
	localparam int unsigned DrainCycles = 20;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: ready is chosen at the falling edge and the word is taken at the rising edge.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready = ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				sb.check_result({res.compare_a, res.compare_b, res.compare_c,
					res.sector_index, res.magnitude_limited});
				words_moved++;
			end
		end
	end

	// Watchdog: a long run of cycles with no word moving on either channel is a hang.
	initial begin
		int unsigned quiet;
		int unsigned last_moved;
		quiet = 0;
		last_moved = 0;
		forever begin
			@(negedge clk);
			if (words_moved != last_moved || !arst_n) begin
				quiet = 0;
				last_moved = words_moved;
			end else begin
				quiet++;
			end
			if (quiet >= StallLimit) begin
				$display("space_vector_pwm_duty_top_test: done, errors");
				$finish;
			end
		end
	end

	// Register write: one cycle of write enable; the scoreboard copy follows at that edge.
	task automatic write_reg(svpwm_pkg::cfg_index_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			svpwm_pkg::CFG_SUPPLY: sb.supply = value;
			svpwm_pkg::CFG_PERIOD: sb.period = value;
			default: sb.swap_bc = value[0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Sends one command word, with random idle cycles before it as the sender odds say.
	// Valid stays high from one word to the next when there is no idle cycle in between.
	task automatic send_command(logic signed [15:0] ua, logic signed [15:0] ub);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid = 1'b0;
			@(negedge clk);
		end
		cmd.valid = 1'b1;
		cmd.u_alpha = ua;
		cmd.u_beta = ub;
		do
			@(posedge clk);
		while (!cmd.ready);
		sb.note_command(ua, ub);
		words_moved++;
	endtask

	// Holds the sender back until every outstanding word has come out, then lets the
	// pipeline settle so that a register write finds the block idle.
	task automatic drain();
		@(negedge clk);
		cmd.valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Random command: full-range noise, an equal share near the clamp circle, small values
	// around the origin, and points on the axes and the sixty-degree lines.
	task automatic send_random();
		int pick;
		int lim;
		logic signed [15:0] ua;
		logic signed [15:0] ub;
		pick = $urandom_range(99);
		lim = (int'(sb.supply) * 3) / 4;
		if (lim > 32767)
			lim = 32767;
		if (lim < 2)
			lim = 2;
		if (pick < 40) begin
			ua = 16'($urandom);
			ub = 16'($urandom);
		end else if (pick < 80) begin
			ua = 16'(int'($urandom_range(2 * lim)) - lim);
			ub = 16'(int'($urandom_range(2 * lim)) - lim);
		end else if (pick < 90) begin
			ua = 16'(int'($urandom_range(128)) - 64);
			ub = 16'(int'($urandom_range(128)) - 64);
		end else begin
			// On an axis or on a sixty-degree line, where the sector choice flips.
			ua = 16'(int'($urandom_range(2 * lim)) - lim);
			case ($urandom_range(3))
				0: ub = 16'sd0;
				1: begin ub = ua; ua = 16'sd0; end
				2: ub = 16'((int'(ua) * 443) / 256);
				default: ub = 16'(-((int'(ua) * 443) / 256));
			endcase
		end
		// Pick the idling stretch from how far the random part has come.
		case ((items_sent * 3) / RandomItems)
			0: begin send_idle_pct = 9; recv_idle_pct = 45; end
			1: begin send_idle_pct = 45; recv_idle_pct = 9; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
		send_command(ua, ub);
		items_sent++;
	endtask

	initial begin
		logic [15:0] supplies[7];
		logic [15:0] periods[7];
		logic swaps[7];
		int per_phase;
		sb = new();
		sb.restore_defaults();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = svpwm_pkg::CFG_SUPPLY;
		cfg_data = 16'd0;
		cmd.valid = 1'b0;
		cmd.u_alpha = 16'sd0;
		cmd.u_beta = 16'sd0;
		words_moved = 0;
		items_sent = 0;
		send_idle_pct = 9;
		recv_idle_pct = 45;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset settings: origin, extremes, axes and sector edges.
		send_command(16'sd0, 16'sd0);
		send_command(16'sd32767, 16'sd32767);
		send_command(-16'sd32768, -16'sd32768);
		send_command(16'sd32767, -16'sd32768);
		send_command(-16'sd32768, 16'sd32767);
		send_command(16'sd1000, 16'sd0);
		send_command(-16'sd1000, 16'sd0);
		send_command(16'sd0, 16'sd1000);
		send_command(16'sd0, -16'sd1000);
		send_command(16'sd500, 16'sd866);
		send_command(-16'sd500, 16'sd866);
		send_command(-16'sd500, -16'sd866);
		send_command(16'sd500, -16'sd866);
		send_command(16'sd1000, 16'sd300);
		send_command(-16'sd1000, 16'sd300);
		send_command(-16'sd1000, -16'sd300);
		send_command(16'sd1000, -16'sd300);
		send_command(16'sd1773, 16'sd0);
		send_command(16'sd1774, 16'sd0);
		send_command(16'sd1, -16'sd1);
		drain();

		// Settings: both extremes of each register, zero supply, zero and unit period.
		supplies = '{16'd65535, 16'd1, 16'd0, 16'd3072, 16'd200, 16'd40000, 16'd2000};
		periods = '{16'd65535, 16'd1, 16'd4095, 16'd0, 16'd1000, 16'd65535, 16'd12345};
		swaps = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
		per_phase = RandomItems / 7;
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(svpwm_pkg::CFG_SUPPLY, supplies[ph]);
			write_reg(svpwm_pkg::CFG_PERIOD, periods[ph]);
			write_reg(svpwm_pkg::CFG_SWAP, {15'd0, swaps[ph]});
			// The origin matters most under zero supply, where the denominator vanishes.
			send_command(16'sd0, 16'sd0);
			for (int i = 0; i < per_phase; i++) begin
				send_random();
				// Once, halfway through, the sender waits for the pipeline to empty.
				if (ph == 3 && i == per_phase / 2)
					drain();
			end
			drain();
		end

		@(negedge clk);
		cmd.valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("space_vector_pwm_duty_top_test: done, clean");
		else
			$display("space_vector_pwm_duty_top_test: done, errors");
		$finish;
	end

endmodule
